// ===== rtl/core/joystick_event_qualifier_defines.svh =====
// Assertion macros shared by the joystick event qualifier modules.
// Each macro expects a signal named clk in the enclosing module; all but JEQ_ASSERT_NXT_RST also expect rst_n.
`ifndef JOYSTICK_EVENT_QUALIFIER_DEFINES_SVH
`define JOYSTICK_EVENT_QUALIFIER_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define JEQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define JEQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define JEQ_ASSERT_NXT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/jeq_pkg.sv =====
package jeq_pkg;

  // Default debounce window in milliseconds.
  localparam int unsigned DEBOUNCE_MS_DEF = 30;

  // Configuration register indexes.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_CENTRE_X       = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_CENTRE_Y       = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_AXES_ENABLED   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_TRIGGER_OFFSET = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_RELEASE_OFFSET = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_REPEAT_DELAY   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_REPEAT_INTVL   = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] CFG_LONG_PRESS     = 3'd7;
  localparam int unsigned CFG_DATA_W = 16;

  // Reset values of the configuration registers.
  localparam logic [11:0] CENTRE_RST       = 12'd2047;
  localparam logic [11:0] TRIGGER_RST      = 12'd500;
  localparam logic [11:0] RELEASE_RST      = 12'd300;
  localparam logic [15:0] REPEAT_DELAY_RST = 16'd400;
  localparam logic [15:0] REPEAT_INTVL_RST = 16'd120;
  localparam logic [15:0] LONG_PRESS_RST   = 16'd700;

  // Event codes reported per poll.
  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_UP    = 3'd1,
    EV_DOWN  = 3'd2,
    EV_LEFT  = 3'd3,
    EV_RIGHT = 3'd4,
    EV_CLICK = 3'd5,
    EV_LONG  = 3'd6
  } ev_t;

  // Axis direction codes.
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd2
  } dir_t;

  // Configuration register file as seen by the evaluation engine.
  typedef struct packed {
    logic [11:0] centre_x;
    logic [11:0] centre_y;
    logic        axes_enabled;
    logic [11:0] trigger_offset;
    logic [11:0] release_offset;
    logic [15:0] repeat_delay_ms;
    logic [15:0] repeat_interval_ms;
    logic [15:0] long_press_ms;
  } cfg_t;

  // One poll item.
  typedef struct packed {
    logic [31:0] now_ms;
    logic        button_down;
    logic [11:0] x_sample;
    logic [11:0] y_sample;
  } poll_t;

  // One result item.
  typedef struct packed {
    ev_t  event_res;
    logic button_held;
  } res_t;

endpackage

// ===== rtl/core/jeq_engine.sv =====
`include "joystick_event_qualifier_defines.svh"

module jeq_engine #(
  parameter int unsigned DEBOUNCE_MS = jeq_pkg::DEBOUNCE_MS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  jeq_pkg::cfg_t  cfg,
  input  jeq_pkg::poll_t poll,
  output jeq_pkg::res_t  res
);
  import jeq_pkg::*;

  localparam logic [31:0] DEBOUNCE_LIM = 32'(DEBOUNCE_MS);

  // Button and axis state.
  logic        bs_r, bs_nxt;
  logic        ls_r, ls_nxt;
  logic [31:0] bct_r, bct_nxt;
  logic [31:0] bpt_r, bpt_nxt;
  dir_t        hx_r, hx_nxt;
  dir_t        hy_r, hy_nxt;
  logic [31:0] hxs_r, hxs_nxt;
  logic [31:0] hys_r, hys_nxt;
  logic [31:0] hxf_r, hxf_nxt;
  logic [31:0] hyf_r, hyf_nxt;

  logic        chg;
  logic        click;
  logic        long_hit;
  logic [31:0] dt_press;
  dir_t        dx;
  dir_t        dy;
  logic        x_fire;
  logic        y_fire;
  ev_t         ev;

  // Classify one axis against its centre with hysteresis.
  function automatic dir_t classify(input logic [11:0] sample, input logic [11:0] centre,
                                    input dir_t prev, input logic [11:0] trig,
                                    input logic [11:0] rel);
    logic signed [12:0] off;
    logic signed [12:0] thr;
    logic signed [12:0] neg_thr;
    off     = $signed({1'b0, sample}) - $signed({1'b0, centre});
    thr     = $signed({1'b0, (prev != DIR_NONE) ? rel : trig});
    neg_thr = -thr;
    if (off > thr) begin
      return DIR_POS;
    end else if (off < neg_thr) begin
      return DIR_NEG;
    end
    return DIR_NONE;
  endfunction

  assign dx = classify(poll.x_sample, cfg.centre_x, hx_r, cfg.trigger_offset,
                       cfg.release_offset);
  assign dy = classify(poll.y_sample, cfg.centre_y, hy_r, cfg.trigger_offset,
                       cfg.release_offset);

  // Debounce, click detection and axis auto-repeat for the current poll.
  always_comb begin
    bs_nxt  = bs_r;
    ls_nxt  = ls_r;
    bct_nxt = bct_r;
    bpt_nxt = bpt_r;
    hx_nxt  = hx_r;
    hy_nxt  = hy_r;
    hxs_nxt = hxs_r;
    hys_nxt = hys_r;
    hxf_nxt = hxf_r;
    hyf_nxt = hyf_r;
    x_fire  = 1'b0;
    y_fire  = 1'b0;
    ev      = EV_NONE;

    chg = (poll.button_down != bs_r) && ((poll.now_ms - bct_r) > DEBOUNCE_LIM);
    if (chg) begin
      bs_nxt  = poll.button_down;
      bct_nxt = poll.now_ms;
      if (poll.button_down) begin
        bpt_nxt = poll.now_ms;
        ls_nxt  = 1'b0;
      end
    end
    click    = chg && !poll.button_down && !ls_r;
    dt_press = poll.now_ms - bpt_nxt;
    long_hit = !click && bs_nxt && !ls_nxt && (dt_press >= {16'd0, cfg.long_press_ms});

    if (click) begin
      ev = EV_CLICK;
    end else if (long_hit) begin
      ls_nxt = 1'b1;
      ev     = EV_LONG;
    end else if (cfg.axes_enabled) begin
      // Horizontal axis has priority.
      if (dx == DIR_NONE) begin
        hx_nxt = DIR_NONE;
      end else if (dx != hx_r) begin
        hx_nxt  = dx;
        hxs_nxt = poll.now_ms;
        hxf_nxt = poll.now_ms;
        x_fire  = 1'b1;
      end else if (((poll.now_ms - hxs_r) >= {16'd0, cfg.repeat_delay_ms}) &&
                   ((poll.now_ms - hxf_r) >= {16'd0, cfg.repeat_interval_ms})) begin
        hxf_nxt = poll.now_ms;
        x_fire  = 1'b1;
      end

      if (x_fire) begin
        ev = (dx == DIR_POS) ? EV_RIGHT : EV_LEFT;
      end else if (hx_nxt == DIR_NONE) begin
        // Vertical axis only while no horizontal direction is held.
        if (dy == DIR_NONE) begin
          hy_nxt = DIR_NONE;
        end else if (dy != hy_r) begin
          hy_nxt  = dy;
          hys_nxt = poll.now_ms;
          hyf_nxt = poll.now_ms;
          y_fire  = 1'b1;
        end else if (((poll.now_ms - hys_r) >= {16'd0, cfg.repeat_delay_ms}) &&
                     ((poll.now_ms - hyf_r) >= {16'd0, cfg.repeat_interval_ms})) begin
          hyf_nxt = poll.now_ms;
          y_fire  = 1'b1;
        end
        if (y_fire) begin
          ev = (dy == DIR_POS) ? EV_DOWN : EV_UP;
        end
      end
    end
  end

  assign res.event_res   = ev;
  assign res.button_held = bs_nxt;

  // State advances once per transaction that leaves the input stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bs_r  <= 1'b0;
      ls_r  <= 1'b0;
      bct_r <= '0;
      bpt_r <= '0;
      hx_r  <= DIR_NONE;
      hy_r  <= DIR_NONE;
      hxs_r <= '0;
      hys_r <= '0;
      hxf_r <= '0;
      hyf_r <= '0;
    end else if (adv) begin
      bs_r  <= bs_nxt;
      ls_r  <= ls_nxt;
      bct_r <= bct_nxt;
      bpt_r <= bpt_nxt;
      hx_r  <= hx_nxt;
      hy_r  <= hy_nxt;
      hxs_r <= hxs_nxt;
      hys_r <= hys_nxt;
      hxf_r <= hxf_nxt;
      hyf_r <= hyf_nxt;
    end
  end

  // Axis events never appear while the axes are disabled.
  `JEQ_ASSERT_NOW(a_no_axis_when_off, adv && !cfg.axes_enabled,
    ev == EV_NONE || ev == EV_CLICK || ev == EV_LONG, "axis event while axes disabled")
  // A click is only reported on a debounced release.
  `JEQ_ASSERT_NXT(a_click_releases, adv && ev == EV_CLICK, !bs_r,
    "click without debounced release")
  // A long click marks the press as already reported.
  `JEQ_ASSERT_NXT(a_long_marks_sent, adv && ev == EV_LONG, ls_r && bs_r,
    "long click did not set the sent flag")

endmodule

// ===== rtl/core/joystick_event_qualifier.sv =====
// Joystick event qualifier.
// Poll items enter on the in_ stream, one transaction per poll; every poll
// produces exactly one result transaction on the out_ stream carrying the
// event code and the debounced button level.
// The block has an input register and a result register; all evaluation
// (button debounce, click and long click, axis hysteresis and auto-repeat)
// sits between them. An input transaction passes through the input register and
// then the result register before its result transaction is offered, and a
// new poll is taken every cycle at full rate while out_tready stays high.
// When out_tready is low the result register holds its transaction; the input
// register still takes one more poll, then in_tready drops until the result
// is taken. No poll is dropped or duplicated.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata and should only
// change while no poll is in flight.
// Synchronous active-low reset clears both registers, the button and axis
// state and restores the register defaults; axis events start disabled.
module joystick_event_qualifier #(
  parameter int unsigned DEBOUNCE_MS = jeq_pkg::DEBOUNCE_MS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [63:0]                       in_tdata,  // now_ms[31:0], button_down[32],
                                                       // x_sample[44:33], y_sample[56:45]
  // Result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata, // event_res[2:0], button_held[3]
  // Configuration write port
  input  logic                              cfg_we,
  input  logic [jeq_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [jeq_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import jeq_pkg::*;

  cfg_t        cfg_r;
  logic        s1_vld_r;
  poll_t       s1_poll_r;
  logic        out_vld_r;
  res_t        out_res_r;
  res_t        res;
  logic        s1_adv;
  logic        in_acc;

  // Stage handshake.
  assign s1_adv    = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.centre_x           <= CENTRE_RST;
      cfg_r.centre_y           <= CENTRE_RST;
      cfg_r.axes_enabled       <= 1'b0;
      cfg_r.trigger_offset     <= TRIGGER_RST;
      cfg_r.release_offset     <= RELEASE_RST;
      cfg_r.repeat_delay_ms    <= REPEAT_DELAY_RST;
      cfg_r.repeat_interval_ms <= REPEAT_INTVL_RST;
      cfg_r.long_press_ms      <= LONG_PRESS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_CENTRE_X:       cfg_r.centre_x           <= cfg_wdata[11:0];
        CFG_CENTRE_Y:       cfg_r.centre_y           <= cfg_wdata[11:0];
        CFG_AXES_ENABLED:   cfg_r.axes_enabled       <= cfg_wdata[0];
        CFG_TRIGGER_OFFSET: cfg_r.trigger_offset     <= cfg_wdata[11:0];
        CFG_RELEASE_OFFSET: cfg_r.release_offset     <= cfg_wdata[11:0];
        CFG_REPEAT_DELAY:   cfg_r.repeat_delay_ms    <= cfg_wdata;
        CFG_REPEAT_INTVL:   cfg_r.repeat_interval_ms <= cfg_wdata;
        CFG_LONG_PRESS:     cfg_r.long_press_ms      <= cfg_wdata;
      endcase
    end
  end

  // Input register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_tready) begin
      s1_vld_r <= in_tvalid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_poll_r.now_ms      <= in_tdata[31:0];
      s1_poll_r.button_down <= in_tdata[32];
      s1_poll_r.x_sample    <= in_tdata[44:33];
      s1_poll_r.y_sample    <= in_tdata[56:45];
    end
  end

  jeq_engine #(
    .DEBOUNCE_MS (DEBOUNCE_MS)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (s1_adv),
    .cfg   (cfg_r),
    .poll  (s1_poll_r),
    .res   (res)
  );

  // Result register valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {4'd0, out_res_r.button_held, out_res_r.event_res};

  // Reset empties both stages.
  `JEQ_ASSERT_NXT_RST(a_rst_empty, !rst_n, !s1_vld_r && !out_vld_r,
    "pipeline not empty after reset")
  // A stalled input stage keeps its poll.
  `JEQ_ASSERT_NXT(a_s1_hold, s1_vld_r && !s1_adv,
    s1_vld_r && $stable(s1_poll_r), "input stage lost a stalled poll")
  // Every evaluated poll lands in the result register.
  `JEQ_ASSERT_NXT(a_s1_to_out, s1_adv, out_vld_r, "evaluated poll produced no result")

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  import jeq_pkg::*;

  localparam logic [31:0] DEBOUNCE_WIN = DEBOUNCE_MS_DEF;

  // Clock, reset and block inputs, all known from time zero.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // now_ms[31:0], button_down[32], x_sample[44:33],
                                // y_sample[56:45]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // event_res[2:0], button_held[3]
  logic        cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  joystick_event_qualifier dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  typedef struct {
    ev_t  event_res;
    logic button_held;
    int   poll_no;
  } outcome_t;

  // Polls waiting to be sent and outcomes waiting to be observed.
  poll_t    poll_queue[$];
  outcome_t expected_outcomes[$];
  poll_t    cur_poll;
  bit       poll_taken = 1'b0;
  int       polls_in_flight = 0;
  int       polls_accepted = 0;
  int       results_checked = 0;
  int       error_count = 0;
  int       settings_applied = 0;
  int       event_tally[8];

  // Mirror of the configuration registers.
  logic [11:0] cfg_centre_x = CENTRE_RST;
  logic [11:0] cfg_centre_y = CENTRE_RST;
  logic        cfg_axes_on = 1'b0;
  logic [11:0] cfg_trigger = TRIGGER_RST;
  logic [11:0] cfg_release = RELEASE_RST;
  logic [15:0] cfg_delay = REPEAT_DELAY_RST;
  logic [15:0] cfg_interval = REPEAT_INTVL_RST;
  logic [15:0] cfg_long = LONG_PRESS_RST;

  // Mirror of the button and axis state; index 0 is X, index 1 is Y.
  logic        btn_state = 1'b0;
  logic        long_sent = 1'b0;
  logic [31:0] btn_change_ms = '0;
  logic [31:0] btn_press_ms = '0;
  dir_t        axis_held[2] = '{DIR_NONE, DIR_NONE};
  logic [31:0] axis_start[2] = '{32'd0, 32'd0};
  logic [31:0] axis_fired[2] = '{32'd0, 32'd0};

  // Stimulus generator state.
  logic [31:0] clock_ms = '0;
  logic        btn_level = 1'b0;
  bit          bounce_pending = 1'b0;
  int          x_mode = 0;
  int          y_mode = 0;

  // Sender and receiver pacing.
  int burst_left = 1;
  int gap_left = 0;
  int stall_cycle = 0;

  // Direction of one axis with trigger/release hysteresis.
  function automatic dir_t axis_direction(input logic [11:0] sample, input logic [11:0] centre,
                                          input dir_t prev);
    int off;
    int thr;
    off = int'(sample) - int'(centre);
    thr = (prev != DIR_NONE) ? int'(cfg_release) : int'(cfg_trigger);
    if (off > thr) return DIR_POS;
    if (off < -thr) return DIR_NEG;
    return DIR_NONE;
  endfunction

  // Auto-repeat of one axis: a new direction fires at once, a held one after
  // the delay and then once per interval.
  function automatic logic axis_fires(input int ax, input dir_t d, input logic [31:0] now);
    logic [31:0] since_start;
    logic [31:0] since_fire;
    if (d == DIR_NONE) begin
      axis_held[ax] = DIR_NONE;
      return 1'b0;
    end
    if (d != axis_held[ax]) begin
      axis_held[ax] = d;
      axis_start[ax] = now;
      axis_fired[ax] = now;
      return 1'b1;
    end
    since_start = now - axis_start[ax];
    since_fire = now - axis_fired[ax];
    if (since_start < 32'(cfg_delay)) return 1'b0;
    if (since_fire < 32'(cfg_interval)) return 1'b0;
    axis_fired[ax] = now;
    return 1'b1;
  endfunction

  // Event for one poll; the button is handled first and ends the poll if it
  // yields a click or a long click.
  function automatic ev_t qualify_poll(input poll_t p);
    logic [31:0] since_change;
    logic [31:0] since_press;
    dir_t dx;
    dir_t dy;
    since_change = p.now_ms - btn_change_ms;
    if (p.button_down != btn_state && since_change > DEBOUNCE_WIN) begin
      btn_state = p.button_down;
      btn_change_ms = p.now_ms;
      if (p.button_down) begin
        btn_press_ms = p.now_ms;
        long_sent = 1'b0;
      end else if (!long_sent) begin
        return EV_CLICK;
      end
    end
    since_press = p.now_ms - btn_press_ms;
    if (btn_state && !long_sent && since_press >= 32'(cfg_long)) begin
      long_sent = 1'b1;
      return EV_LONG;
    end
    if (!cfg_axes_on) return EV_NONE;
    dx = axis_direction(p.x_sample, cfg_centre_x, axis_held[0]);
    dy = axis_direction(p.y_sample, cfg_centre_y, axis_held[1]);
    if (axis_fires(0, dx, p.now_ms)) return (dx == DIR_POS) ? EV_RIGHT : EV_LEFT;
    if (axis_held[0] != DIR_NONE) return EV_NONE;
    if (axis_fires(1, dy, p.now_ms)) return (dy == DIR_POS) ? EV_DOWN : EV_UP;
    return EV_NONE;
  endfunction

  // Sample for one axis, aimed at a region around the centre and thresholds, or anywhere.
  function automatic logic [11:0] pick_sample(input int mode, input logic [11:0] centre);
    int v;
    int d;
    case (mode)
      0: v = int'(centre) + int'($urandom_range(0, 100)) - 50;
      1: v = int'(centre) + int'(cfg_trigger) + 1 + int'($urandom_range(0, 600));
      2: v = int'(centre) - int'(cfg_trigger) - 1 - int'($urandom_range(0, 600));
      3, 4: begin
        d = ((mode == 3) ? int'(cfg_trigger) : int'(cfg_release)) +
            int'($urandom_range(0, 4)) - 2;
        v = ($urandom_range(0, 1) != 0) ? int'(centre) + d : int'(centre) - d;
      end
      default: v = int'($urandom_range(0, 4095));
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[11:0];
  endfunction

  function automatic int pick_axis_mode();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 0;
    if (r < 5) return 1;
    if (r < 7) return 2;
    if (r == 7) return 3;
    if (r == 8) return 4;
    return 5;
  endfunction

  task automatic queue_poll(input logic [31:0] now, input logic down,
                            input logic [11:0] xs, input logic [11:0] ys);
    poll_t p;
    p.now_ms = now;
    p.button_down = down;
    p.x_sample = xs;
    p.y_sample = ys;
    polls_in_flight++;
    poll_queue.push_back(p);
  endtask

  // Random polls with a mostly advancing clock, a button that is held and
  // released (sometimes bouncing) and axes that dwell in one region a while.
  task automatic queue_random_polls(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      if (bounce_pending) begin
        btn_level = ~btn_level;
        bounce_pending = 1'b0;
        clock_ms = clock_ms + $urandom_range(0, 35);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 5) clock_ms = clock_ms;
        else if (r < 80) clock_ms = clock_ms + $urandom_range(1, 40);
        else if (r < 95) clock_ms = clock_ms + $urandom_range(41, 400);
        else if (r < 98) clock_ms = clock_ms + $urandom_range(401, 3000);
        else if (r < 99) clock_ms = clock_ms + $urandom_range(60000, 70000);
        else if ($urandom_range(0, 1) != 0) clock_ms = $urandom();
        else clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 500);
        if ($urandom_range(0, 14) == 0) begin
          btn_level = ~btn_level;
          bounce_pending = ($urandom_range(0, 3) == 0);
        end
      end
      if ($urandom_range(0, 9) == 0) x_mode = pick_axis_mode();
      if ($urandom_range(0, 9) == 0) y_mode = pick_axis_mode();
      queue_poll(clock_ms, btn_level, pick_sample(x_mode, cfg_centre_x),
                 pick_sample(y_mode, cfg_centre_y));
    end
  endtask

  // Register write, one per cycle, mirrored at once since the block is idle.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [15:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= value;
    case (addr)
      CFG_CENTRE_X:       cfg_centre_x = value[11:0];
      CFG_CENTRE_Y:       cfg_centre_y = value[11:0];
      CFG_AXES_ENABLED:   cfg_axes_on = value[0];
      CFG_TRIGGER_OFFSET: cfg_trigger = value[11:0];
      CFG_RELEASE_OFFSET: cfg_release = value[11:0];
      CFG_REPEAT_DELAY:   cfg_delay = value;
      CFG_REPEAT_INTVL:   cfg_interval = value;
      CFG_LONG_PRESS:     cfg_long = value;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [15:0] cx, input logic [15:0] cy,
                               input logic [15:0] axes_on, input logic [15:0] trig,
                               input logic [15:0] rel, input logic [15:0] delay_ms,
                               input logic [15:0] intvl_ms, input logic [15:0] long_ms);
    write_reg(CFG_CENTRE_X, cx);
    write_reg(CFG_CENTRE_Y, cy);
    write_reg(CFG_AXES_ENABLED, axes_on);
    write_reg(CFG_TRIGGER_OFFSET, trig);
    write_reg(CFG_RELEASE_OFFSET, rel);
    write_reg(CFG_REPEAT_DELAY, delay_ms);
    write_reg(CFG_REPEAT_INTVL, intvl_ms);
    write_reg(CFG_LONG_PRESS, long_ms);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  // Holds off until every queued poll has produced its checked result.
  task automatic wait_idle();
    while (polls_in_flight != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  // Input driver: bursts of polls separated by random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !poll_taken) begin
      // Current transaction not yet accepted; hold it.
    end else begin
      poll_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (poll_queue.size() > 0) begin
        cur_poll = poll_queue.pop_front();
        in_tdata <= {7'd0, cur_poll.y_sample, cur_poll.x_sample, cur_poll.button_down,
                     cur_poll.now_ms};
        in_tvalid <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 10);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: cycles through always ready, random stalls, a short
  // periodic pattern and long stalls.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      stall_cycle++;
      case ((stall_cycle >> 9) % 4)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 9) < 6);
        2: out_tready <= (stall_cycle % 8 < 5);
        default: out_tready <= (stall_cycle % 32 >= 20);
      endcase
    end
  end

  // Monitor: checks result transactions, then predicts for accepted polls.
  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        event_tally[out_tdata[2:0]]++;
        if (expected_outcomes.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected nothing, got event %0d held %b",
                   $time, out_tdata[2:0], out_tdata[3]);
        end else begin
          want = expected_outcomes.pop_front();
          polls_in_flight--;
          results_checked++;
          if (out_tdata[2:0] !== want.event_res || out_tdata[3] !== want.button_held) begin
            error_count++;
            $display("%0t: poll %0d mismatch, expected event %0d held %b, got event %0d held %b",
                     $time, want.poll_no, want.event_res, want.button_held,
                     out_tdata[2:0], out_tdata[3]);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        poll_taken = 1'b1;
        got.event_res = qualify_poll(cur_poll);
        got.button_held = btn_state;
        got.poll_no = polls_accepted;
        expected_outcomes.push_back(got);
        polls_accepted++;
      end
    end
  end

  // Stimulus sequence.
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    repeat (2) @(negedge clk);

    // Reset settings, axes off: debounce edge, long click, click, no click
    // after a long click.
    queue_poll(32'd0, 1'b0, 12'd0, 12'hFFF);
    queue_poll(32'd10, 1'b1, 12'hFFF, 12'd0);
    queue_poll(32'd30, 1'b1, 12'd2047, 12'd2047);
    queue_poll(32'd31, 1'b1, 12'd2047, 12'd2047);
    queue_poll(32'd731, 1'b1, 12'd2047, 12'd2047);
    queue_poll(32'd800, 1'b0, 12'd2047, 12'd2047);
    queue_poll(32'd900, 1'b1, 12'd2047, 12'd2047);
    queue_poll(32'd950, 1'b0, 12'd2047, 12'd2047);
    wait_idle();

    // Axes on: repeat timing, release hysteresis, Y only once X lets go,
    // reversal of a held direction, click over a held axis and across the
    // timestamp wrap.
    apply_setting(16'd2047, 16'd2047, 16'd1, 16'd500, 16'd300, 16'd400, 16'd120, 16'd700);
    queue_poll(32'd1000, 1'b0, 12'd2548, 12'd0);
    queue_poll(32'd1100, 1'b0, 12'd2548, 12'd0);
    queue_poll(32'd1400, 1'b0, 12'd2548, 12'd0);
    queue_poll(32'd1519, 1'b0, 12'd2548, 12'd0);
    queue_poll(32'd1520, 1'b0, 12'd2548, 12'd0);
    queue_poll(32'd1530, 1'b0, 12'd2347, 12'd0);
    queue_poll(32'd1540, 1'b0, 12'd0, 12'd4095);
    queue_poll(32'd1550, 1'b0, 12'd2047, 12'd4095);
    queue_poll(32'd1560, 1'b0, 12'd4095, 12'd2047);
    queue_poll(32'd1600, 1'b1, 12'd4095, 12'd2047);
    queue_poll(32'd1700, 1'b0, 12'd4095, 12'd2047);
    queue_poll(32'hFFFF_FFF0, 1'b1, 12'd2047, 12'd2047);
    queue_poll(32'h0000_0010, 1'b0, 12'd2047, 12'd2047);
    clock_ms = 32'h0000_0020;
    wait_idle();

    // Random phases under a spread of settings, extremes included.
    queue_random_polls(70);
    wait_idle();
    apply_setting(16'd0, 16'd4095, 16'd1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    queue_random_polls(60);
    wait_idle();
    apply_setting(16'd4095, 16'd0, 16'd1, 16'd4095, 16'd4095, 16'd65535, 16'd65535,
                  16'd65535);
    queue_random_polls(40);
    wait_idle();
    apply_setting(16'd1800, 16'd2300, 16'd1, 16'd200, 16'd900, 16'd50, 16'd10, 16'd150);
    queue_random_polls(70);
    wait_idle();
    apply_setting(16'd2047, 16'd2047, 16'd0, 16'd500, 16'd300, 16'd400, 16'd120, 16'd300);
    queue_random_polls(50);
    wait_idle();
    for (int k = 0; k < 4; k++) begin
      apply_setting(16'($urandom_range(1000, 3000)), 16'($urandom_range(1000, 3000)), 16'd1,
                    16'($urandom_range(50, 1200)), 16'($urandom_range(0, 1400)),
                    16'($urandom_range(0, 600)), 16'($urandom_range(0, 200)),
                    16'($urandom_range(0, 1500)));
      queue_random_polls(60);
      wait_idle();
    end
    apply_setting(16'd2047, 16'd2047, 16'd1, 16'd1000, 16'd200, 16'd0, 16'd50, 16'd2000);
    queue_random_polls(70);
    wait_idle();
    repeat (10) @(negedge clk);

    $display("Checked %0d polls against %0d results under %0d register settings.",
             polls_accepted, results_checked, settings_applied);
    $display("Events seen: none %0d, up %0d, down %0d, left %0d, right %0d, click %0d, long %0d.",
             event_tally[EV_NONE], event_tally[EV_UP], event_tally[EV_DOWN],
             event_tally[EV_LEFT], event_tally[EV_RIGHT], event_tally[EV_CLICK],
             event_tally[EV_LONG]);
    if (error_count == 0 && expected_outcomes.size() == 0) begin
      $display("joystick_event_qualifier verification clean");
    end else begin
      $display("joystick_event_qualifier verification failed");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #3000000;
    $display("joystick_event_qualifier verification failed");
    $finish;
  end

endmodule
